/* hw/rtl/exgd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// exgd_pkg
// Shared types and constants for the Exp-Golomb stream decoder.
// ----------------------------------------------------------------------------
package exgd_pkg;

   localparam int unsigned MAX_ZEROS  = 32;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned VAL_W      = 32;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned NCODE_W    = 4;

   localparam logic [1:0] STAT_CODE  = 2'd0;
   localparam logic [1:0] STAT_TRUNC = 2'd1;
   localparam logic [1:0] STAT_END   = 2'd2;

   typedef struct packed {
      logic              reading_suffix;
      logic [CNT_W-1:0]  zero_count;
      logic [CNT_W-1:0]  suffix_left;
      logic [VAL_W-1:0]  accumulator;
      logic              code_started;
   } exgd_state_type;

   localparam exgd_state_type STATE_RESET = '{
      reading_suffix: 1'b0,
      zero_count:     '0,
      suffix_left:    '0,
      accumulator:    32'd1,
      code_started:   1'b0
   };

   typedef struct packed {
      logic [BYTE_BITS-1:0][VAL_W-1:0] vals;
      logic [NCODE_W-1:0]              ncode;
      logic                            close;
      logic [1:0]                      close_status;
   } exgd_result_type;

endpackage
`default_nettype wire

/* hw/rtl/exgd_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// exgd_step
// Decodes the eight bits of one byte, MSB first, against the decoder state.
// ----------------------------------------------------------------------------
module exgd_step (
   input  wire logic [7:0]              data_byte,
   input  wire logic                    packet_end,
   input  wire exgd_pkg::exgd_state_type state_cur,
   output exgd_pkg::exgd_state_type     state_nxt,
   output exgd_pkg::exgd_result_type    result
);

   always_comb begin
      exgd_pkg::exgd_state_type s;
      logic [exgd_pkg::NCODE_W-1:0] n;
      logic b;
      s = state_cur;
      n = '0;
      result = '0;
      for (int i = exgd_pkg::BYTE_BITS - 1; i >= 0; i--) begin
         b = data_byte[i];
         if (!s.reading_suffix) begin
            if (!b) begin
               s.code_started = 1'b1;
               s.zero_count = s.zero_count + 1'b1;
               if (s.zero_count >= exgd_pkg::CNT_W'(exgd_pkg::MAX_ZEROS)) begin
                  s.reading_suffix = 1'b1;
                  s.suffix_left = s.zero_count;
                  s.accumulator = 32'd1;
               end
            end else if (s.zero_count == '0) begin
               result.vals[n[2:0]] = '0;
               n = n + 1'b1;
               s.code_started = 1'b0;
            end else begin
               s.reading_suffix = 1'b1;
               s.suffix_left = s.zero_count;
               s.accumulator = 32'd1;
               s.code_started = 1'b1;
            end
         end else begin
            s.accumulator = {s.accumulator[30:0], b};
            s.suffix_left = s.suffix_left - 1'b1;
            if (s.suffix_left == '0) begin
               result.vals[n[2:0]] = s.accumulator - 32'd1;
               n = n + 1'b1;
               s = exgd_pkg::STATE_RESET;
            end
         end
      end
      result.ncode = n;
      result.close = packet_end;
      result.close_status = s.code_started ? exgd_pkg::STAT_TRUNC : exgd_pkg::STAT_END;
      state_nxt = packet_end ? exgd_pkg::STATE_RESET : s;
   end

endmodule
`default_nettype wire

/* hw/rtl/exp_golomb_stream_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// exp_golomb_stream_decoder_unit
// Zero-order Exp-Golomb ue/se decoder over a byte stream.
//
//   channel | dir | fields
//   req_    | in  | data_byte[8], packet_end
//   rsp_    | out | unsigned_value[32], signed_value[32], status[2], last_of_item
//
// A byte is decoded in the cycle it is accepted; its results (0 to 9) are
// registered and drained one per cycle. A new request is taken when the
// result buffer is empty or its last result is being taken. Reset is
// synchronous; rsp_ready low holds the buffer and stalls requests.
// ----------------------------------------------------------------------------
module exp_golomb_stream_decoder_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_packet_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_unsigned_value,
   output logic signed [31:0]      rsp_signed_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last_of_item
);

   exgd_pkg::exgd_state_type  state_ff, state_in, state_step;
   exgd_pkg::exgd_result_type res_step;
   logic [7:0][31:0] vals_ff, vals_in;
   logic [3:0] ncode_ff, ncode_in, nres_ff, nres_in, idx_ff, idx_in;
   logic [1:0] cstat_ff, cstat_in;
   logic busy_ff, busy_in;
   logic take, final_take, accept, is_code;
   logic [3:0] nres_step;
   logic [31:0] v;

   exgd_step u_step (
      .data_byte  (req_data_byte),
      .packet_end (req_packet_end),
      .state_cur  (state_ff),
      .state_nxt  (state_step),
      .result     (res_step)
   );

   assign take       = busy_ff && rsp_ready;
   assign final_take = take && (idx_ff == nres_ff - 4'd1);
   assign req_ready  = !busy_ff || final_take;
   assign accept     = req_valid && req_ready;
   assign nres_step  = res_step.ncode + {3'd0, res_step.close};

   always_comb begin
      state_in = state_ff;
      vals_in  = vals_ff;
      ncode_in = ncode_ff;
      nres_in  = nres_ff;
      idx_in   = idx_ff;
      cstat_in = cstat_ff;
      busy_in  = busy_ff;
      if (take) begin
         idx_in = idx_ff + 4'd1;
         if (final_take) busy_in = 1'b0;
      end
      if (accept) begin
         state_in = state_step;
         vals_in  = res_step.vals;
         ncode_in = res_step.ncode;
         nres_in  = nres_step;
         cstat_in = res_step.close_status;
         idx_in   = '0;
         busy_in  = (nres_step != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= exgd_pkg::STATE_RESET;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         nres_ff  <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         nres_ff  <= nres_in;
      end
      vals_ff  <= vals_in;
      ncode_ff <= ncode_in;
      cstat_ff <= cstat_in;
   end

   assign is_code = idx_ff < ncode_ff;
   assign v       = is_code ? vals_ff[idx_ff[2:0]] : '0;

   assign rsp_valid          = busy_ff;
   assign rsp_unsigned_value = v;
   assign rsp_signed_value   = v[0] ? signed'((v + 32'd1) >> 1) : signed'(32'd0 - (v >> 1));
   assign rsp_status         = is_code ? exgd_pkg::STAT_CODE : cstat_ff;
   assign rsp_last_of_item   = (idx_ff == nres_ff - 4'd1);

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (nres_ff != 4'd0))
      else $error("busy with empty buffer");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < nres_ff))
      else $error("drain index past buffer");
   a_ready_only_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && req_ready) |-> rsp_last_of_item)
      else $error("request taken while results pending");
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_status != exgd_pkg::STAT_CODE) |-> rsp_last_of_item)
      else $error("closing result not last");

endmodule
`default_nettype wire

/* tb/tb_exp_golomb_stream_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_exp_golomb_stream_decoder_unit
// Self-checking bench for the Exp-Golomb stream decoder. Bytes are driven
// through the request channel. A local bit-serial decoder predicts the code
// results and the packet close for each byte. Each response is compared with
// the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [31:0] uval;
   logic [31:0] sval;
   logic [1:0]  stat;
   logic        last;
} code_rec_type;

class exgd_scoreboard;
   code_rec_type  pending_q[$];
   exgd_pkg::exgd_state_type st;
   int            n_codes;
   int            n_trunc;
   int            n_ends;
   int            n_long;
   int            n_err;
   int            n_rsp;

   function new();
      st = exgd_pkg::STATE_RESET;
      n_codes = 0;
      n_trunc = 0;
      n_ends  = 0;
      n_long  = 0;
      n_err   = 0;
      n_rsp   = 0;
   endfunction

   function code_rec_type make_code(logic [31:0] v);
      code_rec_type r;
      r.uval = v;
      r.sval = v[0] ? ((v + 32'd1) >> 1) : (32'd0 - (v >> 1));
      r.stat = exgd_pkg::STAT_CODE;
      r.last = 1'b0;
      return r;
   endfunction

   // decode one request and queue its results
   function void note_request(logic [7:0] b, logic pend);
      code_rec_type cur[$];
      code_rec_type r;
      logic      bit_v;
      for (int i = 7; i >= 0; i--) begin
         bit_v = b[i];
         if (!st.reading_suffix) begin
            if (!bit_v) begin
               st.code_started = 1'b1;
               st.zero_count = st.zero_count + 6'd1;
               if (st.zero_count >= exgd_pkg::MAX_ZEROS) begin
                  st.reading_suffix = 1'b1;
                  st.suffix_left = st.zero_count;
                  st.accumulator = 32'd1;
                  n_long++;
               end
            end else if (st.zero_count == 0) begin
               cur.push_back(make_code(32'd0));
               st.code_started = 1'b0;
            end else begin
               st.reading_suffix = 1'b1;
               st.suffix_left = st.zero_count;
               st.accumulator = 32'd1;
               st.code_started = 1'b1;
            end
         end else begin
            st.accumulator = {st.accumulator[30:0], bit_v};
            st.suffix_left = st.suffix_left - 6'd1;
            if (st.suffix_left == 0) begin
               cur.push_back(make_code(st.accumulator - 32'd1));
               st = exgd_pkg::STATE_RESET;
            end
         end
      end
      n_codes += cur.size();
      if (pend) begin
         r = '0;
         r.stat = st.code_started ? exgd_pkg::STAT_TRUNC : exgd_pkg::STAT_END;
         if (st.code_started) n_trunc++; else n_ends++;
         cur.push_back(r);
         st = exgd_pkg::STATE_RESET;
      end
      if (cur.size() > 0) cur[cur.size()-1].last = 1'b1;
      foreach (cur[k]) pending_q.push_back(cur[k]);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      n_err++;
      $display("MISMATCH %s: got %h want %h (rsp %0d)", what, got, want, n_rsp);
   endtask

   task check_result(logic [31:0] uval, logic [31:0] sval, logic [1:0] stat, logic last);
      code_rec_type w;
      n_rsp++;
      if (pending_q.size() == 0) begin
         report("unexpected response", uval, 32'd0);
         return;
      end
      w = pending_q.pop_front();
      if (uval !== w.uval) report("unsigned", uval, w.uval);
      if (sval !== w.sval) report("signed", sval, w.sval);
      if (stat !== w.stat) report("status", 32'(stat), 32'(w.stat));
      if (last !== w.last) report("last", 32'(last), 32'(w.last));
   endtask
endclass

module tb_exp_golomb_stream_decoder_unit;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_packet_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_unsigned_value;
   logic signed [31:0] rsp_signed_value;
   logic [1:0]  rsp_status;
   logic        rsp_last_of_item;

   exgd_scoreboard board;
   int  cycle_count = 0;
   bit  calm = 1'b0;
   localparam int CYCLE_LIMIT = 200000;

   exp_golomb_stream_decoder_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_packet_end(req_packet_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_unsigned_value(rsp_unsigned_value), .rsp_signed_value(rsp_signed_value),
      .rsp_status(rsp_status), .rsp_last_of_item(rsp_last_of_item)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_exp_golomb_stream_decoder_unit: errors");
         $finish;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_unsigned_value, rsp_signed_value, rsp_status,
                            rsp_last_of_item);
   end

   // receiver stall bursts
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(logic [7:0] b, logic pend);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_packet_end <= pend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(b, pend);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // well-formed codes: random value packed into bytes
   task automatic send_codes(int nbytes, int maxz);
      logic bits[$];
      logic [31:0] v;
      int z;
      logic [7:0] b;
      while (bits.size() < nbytes * 8) begin
         z = $urandom_range(0, maxz);
         v = $urandom;
         for (int i = 0; i < z; i++) bits.push_back(1'b0);
         if (z < exgd_pkg::MAX_ZEROS) bits.push_back(1'b1);
         for (int i = z - 1; i >= 0; i--) bits.push_back(v[i % 32]);
      end
      for (int k = 0; k < nbytes; k++) begin
         for (int i = 7; i >= 0; i--) b[i] = bits.pop_front();
         send(b, k == nbytes - 1);
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all-ones byte, end marker, truncation, small codes
      send(8'hFF, 1'b0);
      send(8'hFF, 1'b1);
      send(8'h00, 1'b1);
      send(8'h40, 1'b0);
      send(8'h5A, 1'b1);
      send(8'h01, 1'b1);
      send(8'h80, 1'b1);
      // long zero run, then 32 one bits: value 2^32 - 2
      repeat (4) send(8'h00, 1'b0);
      repeat (4) send(8'hFF, 1'b0);
      send(8'h80, 1'b1);
      // long zero run with an all-zero suffix: value 2^32 - 1
      repeat (4) send(8'h00, 1'b0);
      send(8'h00, 1'b0);
      repeat (3) send(8'h00, 1'b0);
      send(8'h01, 1'b1);
      // 31 zeros, a 1, a 31-bit suffix
      repeat (3) send(8'h00, 1'b0);
      send(8'h01, 1'b0);
      repeat (4) send(8'hFE, 1'b0);
      send(8'h00, 1'b1);

      // pause until everything drained
      go_idle();
      while (board.pending_q.size() > 0) @(posedge clock);

      // random: mostly well-formed packets, some noise
      for (int p = 0; p < 55; p++) begin
         if ($urandom_range(0, 3) == 0) send(8'($urandom), $urandom_range(0, 3) == 0);
         else if ($urandom_range(0, 9) == 0) send_codes($urandom_range(5, 10), 33);
         else send_codes($urandom_range(1, 5), 6);
      end
      calm = 1'b1;
      for (int p = 0; p < 15; p++) send_codes($urandom_range(1, 4), 5);
      go_idle();

      while (board.pending_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d codes (%0d long-run), %0d truncated and %0d clean packet ends",
               board.n_codes, board.n_long, board.n_trunc, board.n_ends);
      $display("responses checked: %0d, mismatches: %0d", board.n_rsp, board.n_err);
      if (board.n_err == 0)
         $display("tb_exp_golomb_stream_decoder_unit: clean");
      else
         $display("tb_exp_golomb_stream_decoder_unit: errors");
      $finish;
   end
endmodule
`default_nettype wire
